// ===== rtl/dvsd_pkg.sv =====
// Shared types and constants of the debug value stream decoder.
`default_nettype none

package dvsd_pkg;

  // Result kinds as they appear on the output tuser field.
  typedef enum logic [3:0] {
    K_EOM     = 4'd0,
    K_REQ     = 4'd1,
    K_REP     = 4'd2,
    K_ERR     = 4'd3,
    K_NFY     = 4'd4,
    K_INT     = 4'd5,
    K_STR     = 4'd6,
    K_BUF     = 4'd7,
    K_PAYLOAD = 4'd8,
    K_UNUSED  = 4'd9,
    K_UNDEF   = 4'd10,
    K_NULL    = 4'd11,
    K_TRUE    = 4'd12,
    K_FALSE   = 4'd13,
    K_FLOAT   = 4'd14,
    K_ERROR   = 4'd15
  } kind_t;

  // Initial byte tags.
  localparam logic [7:0] TAG_MARKER_MAX = 8'h04;
  localparam logic [7:0] TAG_INT32      = 8'h10;
  localparam logic [7:0] TAG_STR32      = 8'h11;
  localparam logic [7:0] TAG_STR16      = 8'h12;
  localparam logic [7:0] TAG_BUF32      = 8'h13;
  localparam logic [7:0] TAG_BUF16      = 8'h14;
  localparam logic [7:0] TAG_UNUSED     = 8'h15;
  localparam logic [7:0] TAG_FALSE      = 8'h19;
  localparam logic [7:0] TAG_FLOAT      = 8'h1A;
  localparam logic [7:0] TAG_OBJECT     = 8'h1B;
  localparam logic [7:0] TAG_POINTER    = 8'h1C;
  localparam logic [7:0] TAG_LIGHTFUNC  = 8'h1D;
  localparam logic [7:0] TAG_HEAPPTR    = 8'h1E;
  localparam logic [7:0] TAG_SSTR_LO    = 8'h60;
  localparam logic [7:0] TAG_SSTR_HI    = 8'h7F;
  localparam logic [7:0] TAG_SINT_LO    = 8'h80;
  localparam logic [7:0] TAG_SINT_HI    = 8'hBF;
  localparam logic [7:0] TAG_MINT_LO    = 8'hC0;

  // Compact result carried through the queue; the output stage spreads
  // value over the int, length, float and payload fields by kind.
  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic        last;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/dvsd_front.sv =====
// Front end: byte parser that classifies each accepted byte into at most one result.
`default_nettype none

module dvsd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     rx_byte,
  output logic                push,
  output dvsd_pkg::item_t     item
);

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_COLLECT = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_PREFIX  = 6'b001000,
    PH_SIZE    = 6'b010000,
    PH_SKIP    = 6'b100000
  } phase_t;

  phase_t              phase, phase_next;
  dvsd_pkg::kind_t     pending_kind, pending_kind_next;
  logic [31:0]         remaining, remaining_next;
  logic [63:0]         acc, acc_next;

  logic [31:0]         rem_dec;
  logic [63:0]         acc_shift;
  logic                res_valid;
  dvsd_pkg::item_t     res;
  logic [4:0]          sstr_len;

  always_comb begin
    phase_next        = phase;
    pending_kind_next = pending_kind;
    remaining_next    = remaining;
    acc_next          = acc;
    res_valid         = 1'b0;
    res.kind          = dvsd_pkg::K_EOM;
    res.value         = '0;
    res.last          = 1'b0;
    rem_dec           = (remaining != 32'd0) ? remaining - 32'd1 : remaining;
    acc_shift         = {acc[55:0], rx_byte};
    sstr_len          = rx_byte[4:0];

    case (phase)
      PH_COLLECT: begin
        acc_next       = acc_shift;
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          if (pending_kind == dvsd_pkg::K_FLOAT) begin
            res.kind  = dvsd_pkg::K_FLOAT;
            res.value = acc_shift;
          end else if (pending_kind == dvsd_pkg::K_STR ||
                       pending_kind == dvsd_pkg::K_BUF) begin
            res.kind       = pending_kind;
            res.value      = {32'd0, acc_shift[31:0]};
            remaining_next = acc_shift[31:0];
            if (acc_shift[31:0] != 32'd0) phase_next = PH_PAYLOAD;
          end else begin
            res.kind  = dvsd_pkg::K_INT;
            res.value = {32'd0, acc_shift[31:0]};
          end
        end
      end
      PH_PAYLOAD: begin
        remaining_next = rem_dec;
        res_valid      = 1'b1;
        res.kind       = dvsd_pkg::K_PAYLOAD;
        res.value      = {56'd0, rx_byte};
        if (rem_dec == 32'd0) begin
          phase_next = PH_IDLE;
          res.last   = 1'b1;
        end
      end
      PH_PREFIX: begin
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        if (rx_byte == 8'd0) begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          res.kind   = dvsd_pkg::K_UNUSED;
        end else begin
          remaining_next = {24'd0, rx_byte};
          phase_next     = PH_SKIP;
        end
      end
      PH_SKIP: begin
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          res.kind   = dvsd_pkg::K_UNUSED;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (rx_byte <= dvsd_pkg::TAG_MARKER_MAX) begin
          res_valid = 1'b1;
          res.kind  = dvsd_pkg::kind_t'(rx_byte[3:0]);
        end else if (rx_byte == dvsd_pkg::TAG_INT32 || rx_byte == dvsd_pkg::TAG_STR32 ||
                     rx_byte == dvsd_pkg::TAG_STR16 || rx_byte == dvsd_pkg::TAG_BUF32 ||
                     rx_byte == dvsd_pkg::TAG_BUF16 || rx_byte == dvsd_pkg::TAG_FLOAT) begin
          phase_next = PH_COLLECT;
          acc_next   = '0;
          case (rx_byte)
            dvsd_pkg::TAG_INT32: begin
              pending_kind_next = dvsd_pkg::K_INT;
              remaining_next    = 32'd4;
            end
            dvsd_pkg::TAG_STR32: begin
              pending_kind_next = dvsd_pkg::K_STR;
              remaining_next    = 32'd4;
            end
            dvsd_pkg::TAG_STR16: begin
              pending_kind_next = dvsd_pkg::K_STR;
              remaining_next    = 32'd2;
            end
            dvsd_pkg::TAG_BUF32: begin
              pending_kind_next = dvsd_pkg::K_BUF;
              remaining_next    = 32'd4;
            end
            dvsd_pkg::TAG_BUF16: begin
              pending_kind_next = dvsd_pkg::K_BUF;
              remaining_next    = 32'd2;
            end
            default: begin
              pending_kind_next = dvsd_pkg::K_FLOAT;
              remaining_next    = 32'd8;
            end
          endcase
        end else if (rx_byte == dvsd_pkg::TAG_OBJECT) begin
          phase_next     = PH_PREFIX;
          remaining_next = 32'd1;
        end else if (rx_byte == dvsd_pkg::TAG_LIGHTFUNC) begin
          phase_next     = PH_PREFIX;
          remaining_next = 32'd2;
        end else if (rx_byte == dvsd_pkg::TAG_POINTER || rx_byte == dvsd_pkg::TAG_HEAPPTR) begin
          phase_next = PH_SIZE;
        end else if (rx_byte >= dvsd_pkg::TAG_UNUSED && rx_byte <= dvsd_pkg::TAG_FALSE) begin
          res_valid = 1'b1;
          res.kind  = dvsd_pkg::kind_t'(4'(rx_byte - dvsd_pkg::TAG_UNUSED) + 4'd9);
        end else if (rx_byte >= dvsd_pkg::TAG_SSTR_LO && rx_byte <= dvsd_pkg::TAG_SSTR_HI) begin
          // short string: header now, payload follows unless empty
          res_valid      = 1'b1;
          res.kind       = dvsd_pkg::K_STR;
          res.value      = {59'd0, sstr_len};
          remaining_next = {27'd0, sstr_len};
          if (sstr_len != 5'd0) phase_next = PH_PAYLOAD;
        end else if (rx_byte >= dvsd_pkg::TAG_SINT_LO && rx_byte <= dvsd_pkg::TAG_SINT_HI) begin
          res_valid = 1'b1;
          res.kind  = dvsd_pkg::K_INT;
          res.value = {58'd0, rx_byte[5:0]};
        end else if (rx_byte >= dvsd_pkg::TAG_MINT_LO) begin
          // medium integer: high six bits now, low byte next
          phase_next        = PH_COLLECT;
          pending_kind_next = dvsd_pkg::K_INT;
          remaining_next    = 32'd1;
          acc_next          = {58'd0, rx_byte[5:0]};
        end else begin
          res_valid = 1'b1;
          res.kind  = dvsd_pkg::K_ERROR;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pending_kind <= dvsd_pkg::K_EOM;
      remaining    <= 32'd0;
      acc          <= 64'd0;
    end else if (accept) begin
      phase        <= phase_next;
      pending_kind <= pending_kind_next;
      remaining    <= remaining_next;
      acc          <= acc_next;
    end
  end

  assign push = accept && res_valid;
  assign item = res;

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != 32'd0)
    else $error("payload phase with no bytes left");

  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP || phase == PH_PREFIX) |-> remaining != 32'd0)
    else $error("skip phase with no bytes left");

  a_collect_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_COLLECT |-> (remaining != 32'd0 && remaining <= 32'd8))
    else $error("collect count out of range");

endmodule

`default_nettype wire

// ===== rtl/dvsd_queue.sv =====
// Short result queue between the parser and the output stream.
`default_nettype none

module dvsd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dvsd_pkg::item_t push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output dvsd_pkg::item_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dvsd_pkg::item_t  slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !do_pop) count <= count + CW'(1);
      else if (!push && do_pop) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/debug_value_stream_decoder.sv =====
// Top level of the debug value stream decoder: parser, result queue and output stage.
`default_nettype none

// Decodes a debugger wire stream one byte per item. Each accepted byte on the
// s_ side yields zero or one result on the m_ side: markers 0x00-0x04 pass
// through, integers and doubles are assembled big-endian, strings and buffers
// give a header (16-bit length forms reported as their 32-bit kinds) and then
// one payload item per content byte with tlast on the final one, and object,
// pointer, lightfunc and heap-pointer values are skipped by their size byte
// and reported as unused. An illegal initial byte gives an error result.
// Rate: one byte per clock, sustained, for as long as the consumer keeps up;
// the parse state register sets that figure. A result enters the queue as
// its byte is accepted and is shown on the m_ side once the results ahead
// of it are taken. The QUEUE_DEPTH-entry queue absorbs consumer stalls; s_tready
// drops only when it is full, and never depends on m_tready in the same cycle.
module debug_value_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [135:0]       m_tdata,   // [31:0] int_word, [63:32] length,
                                        // [127:64] float_bits, [135:128] payload_byte
  output logic [3:0]         m_tuser,   // [3:0] kind
  output logic               m_tlast    // last
);

  logic             accept;
  logic             push;
  dvsd_pkg::item_t  push_item;
  logic             q_full;
  logic             q_not_empty;
  dvsd_pkg::item_t  head;
  logic [31:0]      int_word;
  logic [31:0]      length;
  logic [63:0]      float_bits;
  logic [7:0]       payload_byte;

  // Take a byte whenever the queue has room for its possible result.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  dvsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_tdata),
    .push    (push),
    .item    (push_item)
  );

  dvsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (m_tready),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // Spread the compact value onto the field that the kind selects; zero the rest.
  always_comb begin
    int_word     = 32'd0;
    length       = 32'd0;
    float_bits   = 64'd0;
    payload_byte = 8'd0;
    case (head.kind)
      dvsd_pkg::K_INT:     int_word     = head.value[31:0];
      dvsd_pkg::K_STR,
      dvsd_pkg::K_BUF:     length       = head.value[31:0];
      dvsd_pkg::K_FLOAT:   float_bits   = head.value;
      dvsd_pkg::K_PAYLOAD: payload_byte = head.value[7:0];
      default: begin
      end
    endcase
  end

  assign m_tvalid = q_not_empty;
  assign m_tdata  = {payload_byte, float_bits, length, int_word};
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  a_last_on_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser == dvsd_pkg::K_PAYLOAD)
    else $error("tlast on a non-payload result");

  a_result_follows_push: assert property (@(posedge clk) disable iff (rst)
    push |=> m_tvalid)
    else $error("queued result not presented");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the debug value stream decoder: random byte streams, scored results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int ITEM_TARGET    = 1700;  // stop the random part after this many bytes
  localparam int WATCHDOG_LIMIT = 2000;  // cycles in a row without any handshake
  localparam int DRAIN_CYCLES   = 8;     // slack after the last result is taken

  // Parser phases of the prediction.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COLLECT,
    PH_PAYLOAD,
    PH_PREFIX,
    PH_SIZE,
    PH_SKIP
  } phase_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_PERIODIC
  } stall_mode_t;

  // One decoded value, field by field as it leaves the block.
  typedef struct packed {
    dvsd_pkg::kind_t kind;
    logic [31:0]     int_word;
    logic [31:0]     length;
    logic [63:0]     float_bits;
    logic [7:0]      payload_byte;
    logic            last;
  } decoded_t;

  // Scoreboard: mirrors the parser state, queues the values each accepted
  // byte decodes to, and checks each result against the oldest one.
  class decode_scoreboard;
    phase_t          phase;
    dvsd_pkg::kind_t pending_kind;
    logic [31:0]     remaining;
    logic [63:0]     acc;
    decoded_t        decoded_q[$];
    int              mismatches;

    function new();
      phase        = PH_IDLE;
      pending_kind = dvsd_pkg::K_EOM;
      remaining    = '0;
      acc          = '0;
      mismatches   = 0;
    endfunction

    function bit is_idle();
      return phase == PH_IDLE;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void start_collect(int unsigned count, dvsd_pkg::kind_t k,
                                logic [63:0] preset);
      phase        = PH_COLLECT;
      remaining    = count;
      pending_kind = k;
      acc          = preset;
    endfunction

    // Emit a string/buffer header and arm the payload phase if non-empty.
    function decoded_t string_header(dvsd_pkg::kind_t k, logic [31:0] len);
      decoded_t r;
      r        = '0;
      r.kind   = k;
      r.length = len;
      phase     = (len != 0) ? PH_PAYLOAD : PH_IDLE;
      remaining = len;
      return r;
    endfunction

    // Advance the parser by one byte; return 1 when the byte yields a result.
    function bit decode_byte(input logic [7:0] b, output decoded_t r);
      r = '0;
      case (phase)
        PH_COLLECT: begin
          acc = {acc[55:0], b};
          if (remaining != 0) remaining--;
          if (remaining != 0) return 1'b0;
          phase = PH_IDLE;
          case (pending_kind)
            dvsd_pkg::K_FLOAT: begin
              r.kind       = dvsd_pkg::K_FLOAT;
              r.float_bits = acc;
            end
            dvsd_pkg::K_STR, dvsd_pkg::K_BUF: r = string_header(pending_kind, acc[31:0]);
            default: begin
              r.kind     = dvsd_pkg::K_INT;
              r.int_word = acc[31:0];
            end
          endcase
          return 1'b1;
        end
        PH_PAYLOAD: begin
          if (remaining != 0) remaining--;
          r.kind         = dvsd_pkg::K_PAYLOAD;
          r.payload_byte = b;
          if (remaining == 0) begin
            phase  = PH_IDLE;
            r.last = 1'b1;
          end
          return 1'b1;
        end
        PH_PREFIX: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) phase = PH_SIZE;
          return 1'b0;
        end
        PH_SIZE: begin
          if (b == 0) begin
            phase  = PH_IDLE;
            r.kind = dvsd_pkg::K_UNUSED;
            return 1'b1;
          end
          remaining = {24'b0, b};
          phase     = PH_SKIP;
          return 1'b0;
        end
        PH_SKIP: begin
          if (remaining != 0) remaining--;
          if (remaining == 0) begin
            phase  = PH_IDLE;
            r.kind = dvsd_pkg::K_UNUSED;
            return 1'b1;
          end
          return 1'b0;
        end
        default: begin
          phase = PH_IDLE;
          if (b <= dvsd_pkg::TAG_MARKER_MAX) begin
            r.kind = dvsd_pkg::kind_t'(b[3:0]);
            return 1'b1;
          end
          case (b)
            dvsd_pkg::TAG_INT32: begin
              start_collect(4, dvsd_pkg::K_INT, '0);
              return 1'b0;
            end
            dvsd_pkg::TAG_STR32: begin
              start_collect(4, dvsd_pkg::K_STR, '0);
              return 1'b0;
            end
            dvsd_pkg::TAG_STR16: begin
              start_collect(2, dvsd_pkg::K_STR, '0);
              return 1'b0;
            end
            dvsd_pkg::TAG_BUF32: begin
              start_collect(4, dvsd_pkg::K_BUF, '0);
              return 1'b0;
            end
            dvsd_pkg::TAG_BUF16: begin
              start_collect(2, dvsd_pkg::K_BUF, '0);
              return 1'b0;
            end
            dvsd_pkg::TAG_FLOAT: begin
              start_collect(8, dvsd_pkg::K_FLOAT, '0);
              return 1'b0;
            end
            dvsd_pkg::TAG_OBJECT: begin
              phase     = PH_PREFIX;
              remaining = 1;
              return 1'b0;
            end
            dvsd_pkg::TAG_LIGHTFUNC: begin
              phase     = PH_PREFIX;
              remaining = 2;
              return 1'b0;
            end
            dvsd_pkg::TAG_POINTER, dvsd_pkg::TAG_HEAPPTR: begin
              phase = PH_SIZE;
              return 1'b0;
            end
            default: ;
          endcase
          if (b >= dvsd_pkg::TAG_UNUSED && b <= dvsd_pkg::TAG_FALSE) begin
            r.kind = dvsd_pkg::kind_t'(int'(dvsd_pkg::K_UNUSED) +
                                       int'(b - dvsd_pkg::TAG_UNUSED));
          end else if (b >= dvsd_pkg::TAG_SSTR_LO && b <= dvsd_pkg::TAG_SSTR_HI) begin
            r = string_header(dvsd_pkg::K_STR, 32'(b - dvsd_pkg::TAG_SSTR_LO));
          end else if (b >= dvsd_pkg::TAG_SINT_LO && b <= dvsd_pkg::TAG_SINT_HI) begin
            r.kind     = dvsd_pkg::K_INT;
            r.int_word = 32'(b - dvsd_pkg::TAG_SINT_LO);
          end else if (b >= dvsd_pkg::TAG_MINT_LO) begin
            start_collect(1, dvsd_pkg::K_INT, 64'(b - dvsd_pkg::TAG_MINT_LO));
            return 1'b0;
          end else begin
            r.kind = dvsd_pkg::K_ERROR;
          end
          return 1'b1;
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      decoded_t r;
      if (decode_byte(b, r)) decoded_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [3:0] kind, logic [135:0] data, logic last);
      decoded_t e;
      if (decoded_q.size() == 0) begin
        $error("kind: expected no result, got %0d", kind);
        mismatches++;
        return;
      end
      e = decoded_q.pop_front();
      compare_field("kind",         e.kind,         kind);
      compare_field("int_word",     e.int_word,     data[31:0]);
      compare_field("length",       e.length,       data[63:32]);
      compare_field("float_bits",   e.float_bits,   data[127:64]);
      compare_field("payload_byte", e.payload_byte, data[135:128]);
      compare_field("last",         e.last,         last);
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;    // [7:0] rx_byte
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;    // [31:0] int_word, [63:32] length,
                            // [127:64] float_bits, [135:128] payload_byte
  logic [3:0]   m_tuser;    // [3:0] kind
  logic         m_tlast;    // last

  decode_scoreboard sb = new();

  int sent_items;
  int burst_left;
  int idle_cycles;

  debug_value_stream_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one byte from a falling edge and hold it until the block takes it.
  // Bursts of random length are separated by random gaps; now and then a
  // long burst runs the link at full rate.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    sent_items++;
    @(negedge clk);
  endtask

  // Send the low n bytes of v, most significant first, as the wire does.
  task automatic send_word(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) send_byte(v[8*i +: 8]);
  endtask

  task automatic send_random_content(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Send one value with random content. Most are well formed; the rest are
  // illegal tags, truncated values and line noise. After noise, pad with
  // zero bytes until the parser is back at a value boundary. Never let noise
  // open a string or buffer at a boundary: its length would be arbitrary and
  // the payload could swallow the rest of the run.
  task automatic send_random_value();
    int         pick;
    int         n;
    logic [7:0] tag;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_byte(8'($urandom_range(0, dvsd_pkg::TAG_MARKER_MAX)));
    end else if (pick < 14) begin
      send_byte(dvsd_pkg::TAG_INT32);
      send_word($urandom, 4);
    end else if (pick < 30) begin
      // explicit-length string or buffer, kept short most of the time
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
      case ($urandom_range(0, 3))
        0:       tag = dvsd_pkg::TAG_STR32;
        1:       tag = dvsd_pkg::TAG_BUF32;
        2:       tag = dvsd_pkg::TAG_STR16;
        default: tag = dvsd_pkg::TAG_BUF16;
      endcase
      send_byte(tag);
      send_word(n, (tag == dvsd_pkg::TAG_STR16 || tag == dvsd_pkg::TAG_BUF16) ? 2 : 4);
      send_random_content(n);
    end else if (pick < 36) begin
      send_byte(8'($urandom_range(dvsd_pkg::TAG_UNUSED, dvsd_pkg::TAG_FALSE)));
    end else if (pick < 44) begin
      send_byte(dvsd_pkg::TAG_FLOAT);
      send_word($urandom, 4);
      send_word($urandom, 4);
    end else if (pick < 54) begin
      // skipped value: optional prefix, size byte, then that many data bytes
      tag = 8'($urandom_range(dvsd_pkg::TAG_OBJECT, dvsd_pkg::TAG_HEAPPTR));
      send_byte(tag);
      if (tag == dvsd_pkg::TAG_OBJECT) send_random_content(1);
      else if (tag == dvsd_pkg::TAG_LIGHTFUNC) send_random_content(2);
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
      send_byte(8'(n));
      send_random_content(n);
    end else if (pick < 66) begin
      n = $urandom_range(0, dvsd_pkg::TAG_SSTR_HI - dvsd_pkg::TAG_SSTR_LO);
      send_byte(8'(dvsd_pkg::TAG_SSTR_LO + n));
      send_random_content(n);
    end else if (pick < 76) begin
      send_byte(8'($urandom_range(dvsd_pkg::TAG_SINT_LO, dvsd_pkg::TAG_SINT_HI)));
    end else if (pick < 84) begin
      send_byte(8'($urandom_range(dvsd_pkg::TAG_MINT_LO, 8'hFF)));
      send_random_content(1);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'($urandom_range(dvsd_pkg::TAG_MARKER_MAX + 1,
                                    dvsd_pkg::TAG_INT32 - 1)));
      end else begin
        send_byte(8'($urandom_range(dvsd_pkg::TAG_HEAPPTR + 1,
                                    dvsd_pkg::TAG_SSTR_LO - 1)));
      end
    end else begin
      if (pick < 95) begin
        // truncated value: its tag, then noise where the content belongs
        case ($urandom_range(0, 4))
          0:       tag = dvsd_pkg::TAG_INT32;
          1:       tag = dvsd_pkg::TAG_FLOAT;
          2:       tag = dvsd_pkg::TAG_OBJECT;
          3:       tag = dvsd_pkg::TAG_POINTER;
          default: tag = dvsd_pkg::TAG_MINT_LO;
        endcase
        send_byte(tag);
      end
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (sb.is_idle() && b >= dvsd_pkg::TAG_STR32 && b <= dvsd_pkg::TAG_BUF16)
          b = dvsd_pkg::TAG_INT32;
        send_byte(b);
      end
      while (!sb.is_idle()) send_byte(8'h00);
    end
  endtask

  // Receiver: drop tready on a randomly chosen pattern, picked anew for each span.
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    m_tready = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(5, 60);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          RDY_ALWAYS:   m_tready = 1'b1;
          RDY_MOSTLY:   m_tready = ($urandom_range(0, 3) != 0);
          RDY_RARELY:   m_tready = ($urandom_range(0, 3) == 0);
          default:      m_tready = (i % 3 == 0);
        endcase
      end
    end
  end

  // Score every result at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
  end

  // End the run when no item moves on either side for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    bit         drained_once;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    sent_items   = 0;
    burst_left   = 0;
    drained_once = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed values: every marker, integer extremes, each string and
    // buffer length form including an empty one, the simple tags, float
    // extremes, each skipped kind with either a zero size or data, empty
    // and one-byte short strings, integer bounds, and illegal initial bytes.
    directed = '{
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
      dvsd_pkg::TAG_INT32, 8'h80, 8'h00, 8'h00, 8'h00,
      dvsd_pkg::TAG_INT32, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
      dvsd_pkg::TAG_STR32, 8'h00, 8'h00, 8'h00, 8'h02, 8'h41, 8'h42,
      dvsd_pkg::TAG_STR16, 8'h00, 8'h00,
      dvsd_pkg::TAG_BUF32, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
      dvsd_pkg::TAG_BUF16, 8'h00, 8'h01, 8'h00,
      8'h15, 8'h16, 8'h17, 8'h18, 8'h19,
      dvsd_pkg::TAG_FLOAT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      dvsd_pkg::TAG_FLOAT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      dvsd_pkg::TAG_OBJECT, 8'h07, 8'h00,
      dvsd_pkg::TAG_POINTER, 8'h02, 8'hAA, 8'h55,
      dvsd_pkg::TAG_LIGHTFUNC, 8'h01, 8'h02, 8'h03, 8'h11, 8'h22, 8'h33,
      dvsd_pkg::TAG_HEAPPTR, 8'h00,
      dvsd_pkg::TAG_SSTR_LO,
      8'h61, 8'h5A,
      dvsd_pkg::TAG_SINT_LO, dvsd_pkg::TAG_SINT_HI,
      dvsd_pkg::TAG_MINT_LO, 8'h00,
      8'hFF, 8'hFF,
      8'h05, 8'h0F, 8'h1F, 8'h5F
    };
    foreach (directed[i]) send_byte(directed[i]);

    while (sent_items < ITEM_TARGET) begin
      // Hold off once midway until every pending result has been taken.
      if (!drained_once && sent_items >= ITEM_TARGET / 2) begin
        drained_once = 1'b1;
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      send_random_value();
    end
    s_tvalid = 1'b0;

    // Drain: wait for the last results, then leave slack for stragglers.
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== debug_value_stream_decoder.f =====
rtl/dvsd_pkg.sv
rtl/dvsd_front.sv
rtl/dvsd_queue.sv
rtl/debug_value_stream_decoder.sv
tb/tb.sv
